### sv/dept2p_pkg.sv
package dept2p_pkg;

  // Field widths
  localparam int unsigned StatusWidth  = 16;
  localparam int unsigned ControlWidth = 16;
  localparam int unsigned PosWidth     = 32;
  localparam int unsigned SpeedWidth   = 32;
  localparam int unsigned PauseWidth   = 31;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 32;

  // Status word decode
  localparam logic [StatusWidth-1:0] StsMask    = 16'h00EF;
  localparam logic [StatusWidth-1:0] StsReady   = 16'h0021;
  localparam logic [StatusWidth-1:0] StsOn      = 16'h0023;
  localparam logic [StatusWidth-1:0] StsEnabled = 16'h0027;
  localparam int unsigned            StsReachedBit = 10;

  // Control word codes
  localparam logic [ControlWidth-1:0] CwShutdown = 16'h0006;
  localparam logic [ControlWidth-1:0] CwSwitchOn = 16'h0007;
  localparam logic [ControlWidth-1:0] CwEnable   = 16'h000F;
  localparam logic [ControlWidth-1:0] CwGo       = 16'h005F;

  // Saturation limit of the elapsed tick count
  localparam logic [PauseWidth-1:0] ElapsedMax = {PauseWidth{1'b1}};

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_POSITION_A = 3'd0,
    CFG_POSITION_B = 3'd1,
    CFG_SPEED_A    = 3'd2,
    CFG_SPEED_B    = 3'd3,
    CFG_PAUSE_A    = 3'd4,
    CFG_PAUSE_B    = 3'd5
  } cfg_idx_t;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_PAUSE0     = 4'd1,
    PH_WAIT_READY = 4'd2,
    PH_WAIT_ON    = 4'd3,
    PH_WAIT_EN_A  = 4'd4,
    PH_REACH_A    = 4'd5,
    PH_PAUSE_A    = 4'd6,
    PH_WAIT_EN_B  = 4'd7,
    PH_REACH_B    = 4'd8,
    PH_PAUSE_B    = 4'd9,
    PH_LOOP       = 4'd10
  } phase_t;

  // Configuration register contents
  typedef struct packed {
    logic signed [PosWidth-1:0] position_a;
    logic signed [PosWidth-1:0] position_b;
    logic [SpeedWidth-1:0]      speed_a;
    logic [SpeedWidth-1:0]      speed_b;
    logic [PauseWidth-1:0]      pause_a;
    logic [PauseWidth-1:0]      pause_b;
  } cfg_t;

  // One result transaction
  typedef struct packed {
    logic [ControlWidth-1:0]    control_word;
    logic signed [PosWidth-1:0] target_position;
    logic [SpeedWidth-1:0]      profile_velocity;
    logic [PauseWidth-1:0]      elapsed_ticks;
    logic                       mode_write;
  } res_t;

endpackage

### sv/dept2p_cfg_regs.sv
module dept2p_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dept2p_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  logic [dept2p_pkg::CfgDataWidth-1:0]  cfg_data,
  output dept2p_pkg::cfg_t                     cfg
);

  // Writes are always taken; out-of-range indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (dept2p_pkg::cfg_idx_t'(cfg_index))
        dept2p_pkg::CFG_POSITION_A: cfg.position_a <= cfg_data;
        dept2p_pkg::CFG_POSITION_B: cfg.position_b <= cfg_data;
        dept2p_pkg::CFG_SPEED_A:    cfg.speed_a    <= cfg_data;
        dept2p_pkg::CFG_SPEED_B:    cfg.speed_b    <= cfg_data;
        dept2p_pkg::CFG_PAUSE_A:    cfg.pause_a    <= cfg_data[dept2p_pkg::PauseWidth-1:0];
        dept2p_pkg::CFG_PAUSE_B:    cfg.pause_b    <= cfg_data[dept2p_pkg::PauseWidth-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/dept2p_seq.sv
module dept2p_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                fire,
  input  logic [dept2p_pkg::StatusWidth-1:0]  status,
  input  dept2p_pkg::cfg_t                    cfg,
  output dept2p_pkg::res_t                    res
);

  dept2p_pkg::phase_t phase, phase_next;

  logic [dept2p_pkg::PauseWidth-1:0]   delay_count, delay_count_next;
  logic [dept2p_pkg::PauseWidth-1:0]   elapsed_count, elapsed_count_next;
  logic [dept2p_pkg::ControlWidth-1:0] control_reg, control_reg_next;
  logic signed [dept2p_pkg::PosWidth-1:0] target_reg, target_reg_next;
  logic [dept2p_pkg::SpeedWidth-1:0]   velocity_reg, velocity_reg_next;

  logic [dept2p_pkg::StatusWidth-1:0] sts_masked;
  logic is_ready, is_on, is_enabled, reached;
  logic delay_done, pause_a_zero, pause_b_zero;

  // Status decode
  assign sts_masked   = status & dept2p_pkg::StsMask;
  assign is_ready     = (sts_masked == dept2p_pkg::StsReady);
  assign is_on        = (sts_masked == dept2p_pkg::StsOn);
  assign is_enabled   = (sts_masked == dept2p_pkg::StsEnabled);
  assign reached      = status[dept2p_pkg::StsReachedBit];
  assign delay_done   = (delay_count == '0);
  assign pause_a_zero = (cfg.pause_a == '0);
  assign pause_b_zero = (cfg.pause_b == '0);

  // Next phase; a zero pause falls straight through to the phase after it
  always_comb begin
    phase_next = phase;
    case (phase)
      dept2p_pkg::PH_START:
        phase_next = pause_a_zero ? dept2p_pkg::PH_WAIT_READY : dept2p_pkg::PH_PAUSE0;
      dept2p_pkg::PH_PAUSE0:
        if (delay_done) phase_next = dept2p_pkg::PH_WAIT_READY;
      dept2p_pkg::PH_WAIT_READY:
        if (is_ready) phase_next = dept2p_pkg::PH_WAIT_ON;
      dept2p_pkg::PH_WAIT_ON:
        if (is_on) phase_next = dept2p_pkg::PH_WAIT_EN_A;
      dept2p_pkg::PH_LOOP:
        phase_next = dept2p_pkg::PH_WAIT_EN_A;
      dept2p_pkg::PH_WAIT_EN_A:
        if (is_enabled) phase_next = dept2p_pkg::PH_REACH_A;
      dept2p_pkg::PH_REACH_A:
        if (reached) begin
          phase_next = pause_a_zero ? dept2p_pkg::PH_WAIT_EN_B : dept2p_pkg::PH_PAUSE_A;
        end
      dept2p_pkg::PH_PAUSE_A:
        if (delay_done) phase_next = dept2p_pkg::PH_WAIT_EN_B;
      dept2p_pkg::PH_WAIT_EN_B:
        if (is_enabled) phase_next = dept2p_pkg::PH_REACH_B;
      dept2p_pkg::PH_REACH_B:
        if (reached) begin
          phase_next = pause_b_zero ? dept2p_pkg::PH_LOOP : dept2p_pkg::PH_PAUSE_B;
        end
      dept2p_pkg::PH_PAUSE_B:
        if (delay_done) phase_next = dept2p_pkg::PH_LOOP;
      default:
        phase_next = dept2p_pkg::PH_START;
    endcase
  end

  // Datapath registers: counters and commanded values
  always_comb begin
    delay_count_next   = delay_count;
    elapsed_count_next = elapsed_count;
    control_reg_next   = control_reg;
    target_reg_next    = target_reg;
    velocity_reg_next  = velocity_reg;
    case (phase)
      dept2p_pkg::PH_START: begin
        target_reg_next   = cfg.position_a;
        velocity_reg_next = cfg.speed_a;
        if (!pause_a_zero) delay_count_next = cfg.pause_a - 1'b1;
        else               control_reg_next = dept2p_pkg::CwShutdown;
      end
      dept2p_pkg::PH_PAUSE0: begin
        if (!delay_done) delay_count_next = delay_count - 1'b1;
        else             control_reg_next = dept2p_pkg::CwShutdown;
      end
      dept2p_pkg::PH_WAIT_READY: begin
        if (is_ready) control_reg_next = dept2p_pkg::CwSwitchOn;
      end
      dept2p_pkg::PH_WAIT_ON: begin
        if (is_on) control_reg_next = dept2p_pkg::CwEnable;
      end
      dept2p_pkg::PH_LOOP: begin
        control_reg_next = dept2p_pkg::CwEnable;
      end
      dept2p_pkg::PH_WAIT_EN_A: begin
        if (is_enabled) begin
          target_reg_next   = cfg.position_a;
          velocity_reg_next = cfg.speed_a;
          control_reg_next  = dept2p_pkg::CwGo;
        end
      end
      dept2p_pkg::PH_REACH_A: begin
        if (!reached) begin
          // saturating tick count
          if (elapsed_count != dept2p_pkg::ElapsedMax) begin
            elapsed_count_next = elapsed_count + 1'b1;
          end
        end else if (!pause_a_zero) begin
          delay_count_next = cfg.pause_a - 1'b1;
        end else begin
          elapsed_count_next = '0;
          control_reg_next   = dept2p_pkg::CwEnable;
        end
      end
      dept2p_pkg::PH_PAUSE_A: begin
        if (!delay_done) begin
          delay_count_next = delay_count - 1'b1;
        end else begin
          elapsed_count_next = '0;
          control_reg_next   = dept2p_pkg::CwEnable;
        end
      end
      dept2p_pkg::PH_WAIT_EN_B: begin
        if (is_enabled) begin
          target_reg_next   = cfg.position_b;
          velocity_reg_next = cfg.speed_b;
          control_reg_next  = dept2p_pkg::CwGo;
        end
      end
      dept2p_pkg::PH_REACH_B: begin
        if (reached && !pause_b_zero) delay_count_next = cfg.pause_b - 1'b1;
      end
      dept2p_pkg::PH_PAUSE_B: begin
        if (!delay_done) delay_count_next = delay_count - 1'b1;
      end
      default: ;
    endcase
  end

  // Result of this tick: values after the step
  always_comb begin
    res.control_word     = control_reg_next;
    res.target_position  = target_reg_next;
    res.profile_velocity = velocity_reg_next;
    res.elapsed_ticks    = elapsed_count_next;
    res.mode_write       = (phase == dept2p_pkg::PH_START);
  end

  // State update, one step per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dept2p_pkg::PH_START;
      delay_count   <= '0;
      elapsed_count <= '0;
      control_reg   <= '0;
      target_reg    <= '0;
      velocity_reg  <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      delay_count   <= delay_count_next;
      elapsed_count <= elapsed_count_next;
      control_reg   <= control_reg_next;
      target_reg    <= target_reg_next;
      velocity_reg  <= velocity_reg_next;
    end
  end

  // Start phase is left for good after the first tick
  a_start_once: assert property (@(posedge clk) disable iff (rst)
    fire |=> (phase != dept2p_pkg::PH_START))
    else $error("sequencer returned to start phase");

  // Delay counter only holds a value inside a pause
  a_delay_in_pause: assert property (@(posedge clk) disable iff (rst)
    (phase != dept2p_pkg::PH_PAUSE0 && phase != dept2p_pkg::PH_PAUSE_A &&
     phase != dept2p_pkg::PH_PAUSE_B) |-> (delay_count == '0))
    else $error("delay count nonzero outside a pause");

  // Elapsed count moves only around the A move
  a_elapsed_hold: assert property (@(posedge clk) disable iff (rst)
    (fire && phase != dept2p_pkg::PH_REACH_A && phase != dept2p_pkg::PH_PAUSE_A)
    |=> $stable(elapsed_count))
    else $error("elapsed count changed outside the A move");

endmodule

### sv/drive_enable_point_to_point_sequencer_top.sv
// Drive enable and point-to-point sequencer, CiA 402 profile position.
// Input channel (in_valid / in_stall / status_word): one transaction per
// tick carrying the drive status word. Output channel (out_valid /
// out_stall / payload): exactly one result per input transaction with the
// control word, commanded target and velocity, elapsed ticks of the A move
// and the one-shot mode write flag (set on the first tick after reset).
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): registers
// 0..5 = position A, position B, speed A, speed B, pause A, pause B; other
// indexes are ignored. Write only while no transaction is in flight.
// Timing: input register, one pass of next-state logic, result register.
// A transaction moves from the input register into the result register once
// that is free; with no receiver stall one transaction is taken every cycle.
// The sequencer state advances once per transaction as it moves into the
// result register.
// When the receiver stalls, the result register holds and the input
// register keeps one more transaction; in_stall rises once both are full.
// Synchronous reset clears the sequence, the counters, the config and the valid flags.
module drive_enable_point_to_point_sequencer_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [dept2p_pkg::StatusWidth-1:0]    status_word,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [dept2p_pkg::ControlWidth-1:0]   control_word,
  output logic signed [dept2p_pkg::PosWidth-1:0] target_position,
  output logic [dept2p_pkg::SpeedWidth-1:0]     profile_velocity,
  output logic [dept2p_pkg::PauseWidth-1:0]     elapsed_ticks,
  output logic                                  mode_write,
  // configuration channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dept2p_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [dept2p_pkg::CfgDataWidth-1:0]   cfg_data
);

  dept2p_pkg::cfg_t cfg;
  dept2p_pkg::res_t res;
  dept2p_pkg::res_t out_reg;

  logic                               in_reg_valid;
  logic [dept2p_pkg::StatusWidth-1:0] in_reg_status;
  logic                               advance;
  logic                               fire;

  dept2p_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dept2p_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .status (in_reg_status),
    .cfg    (cfg),
    .res    (res)
  );

  // Handshake: result register frees up when empty or taken
  assign advance  = !out_valid || !out_stall;
  assign fire     = in_reg_valid && advance;
  assign in_stall = in_reg_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_status <= status_word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_reg <= res;
    end
  end

  assign control_word     = out_reg.control_word;
  assign target_position  = out_reg.target_position;
  assign profile_velocity = out_reg.profile_velocity;
  assign elapsed_ticks    = out_reg.elapsed_ticks;
  assign mode_write       = out_reg.mode_write;

  // Input side only stalls while a transaction waits in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_reg_valid && out_valid))
    else $error("input stalled with no transaction pending");

endmodule

### tb/sv/tb_drive_enable_point_to_point_sequencer_top.sv
module tb_drive_enable_point_to_point_sequencer_top;
  import dept2p_pkg::*;

  // Run limits
  localparam int unsigned QuietLimit = 2000;
  // Config indexes past the last register; writes to them must be dropped
  localparam logic [CfgIdxWidth-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CfgSpareHi = 3'd7;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [StatusWidth-1:0]      status_word;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [ControlWidth-1:0]     control_word;
  logic signed [PosWidth-1:0]  target_position;
  logic [SpeedWidth-1:0]       profile_velocity;
  logic [PauseWidth-1:0]       elapsed_ticks;
  logic                        mode_write;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CfgIdxWidth-1:0]      cfg_index;
  logic [CfgDataWidth-1:0]     cfg_data;

  drive_enable_point_to_point_sequencer_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .status_word      (status_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .control_word     (control_word),
    .target_position  (target_position),
    .profile_velocity (profile_velocity),
    .elapsed_ticks    (elapsed_ticks),
    .mode_write       (mode_write),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Sequencer model state and its copy of the registers
  cfg_t                       drive_cfg;
  phase_t                     seq_phase;
  logic [PauseWidth-1:0]      wait_left;
  logic [PauseWidth-1:0]      ticks_on_a;
  logic [ControlWidth-1:0]    ctl_now;
  logic signed [PosWidth-1:0] target_now;
  logic [SpeedWidth-1:0]      speed_now;

  // Drive commands still owed by the block, oldest first
  res_t expected_commands[$];

  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned rx_hold = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned ticks_sent = 0;
  int unsigned commands_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned round_trips = 0;
  logic [PauseWidth-1:0] peak_elapsed = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // Pause register value; bit 31 is junk the block must drop
  function automatic logic [31:0] rand_pause();
    int unsigned r;
    logic [PauseWidth-1:0] ticks;
    r = $urandom_range(0, 99);
    if (r < 30) ticks = '0;
    else if (r < 90) ticks = 31'($urandom_range(1, 4));
    else ticks = 31'($urandom_range(5, 20));
    return {1'($urandom_range(0, 1)), ticks};
  endfunction

  function automatic void reset_sequencer_model();
    drive_cfg  = '0;
    seq_phase  = PH_START;
    wait_left  = '0;
    ticks_on_a = '0;
    ctl_now    = '0;
    target_now = '0;
    speed_now  = '0;
  endfunction

  // Advance the sequence by one tick and return the command it holds
  function automatic res_t next_drive_command(input logic [StatusWidth-1:0] sw);
    res_t cmd;
    logic [StatusWidth-1:0] s;
    logic is_first;
    bit busy;
    s = sw & StsMask;
    is_first = (seq_phase == PH_START);
    busy = 1'b1;
    while (busy) begin
      case (seq_phase)
        PH_START: begin
          target_now = drive_cfg.position_a;
          speed_now  = drive_cfg.speed_a;
          wait_left  = drive_cfg.pause_a;
          seq_phase  = PH_PAUSE0;
        end
        PH_PAUSE0: begin
          if (wait_left != 0) begin
            wait_left = wait_left - 1'b1;
          end else begin
            ctl_now   = CwShutdown;
            seq_phase = PH_WAIT_READY;
          end
          busy = 1'b0;
        end
        PH_WAIT_READY: begin
          if (s == StsReady) begin
            ctl_now   = CwSwitchOn;
            seq_phase = PH_WAIT_ON;
          end
          busy = 1'b0;
        end
        PH_WAIT_ON: begin
          if (s == StsOn) seq_phase = PH_LOOP;
          else busy = 1'b0;
        end
        PH_LOOP: begin
          ctl_now   = CwEnable;
          seq_phase = PH_WAIT_EN_A;
          busy      = 1'b0;
        end
        PH_WAIT_EN_A: begin
          if (s == StsEnabled) begin
            target_now = drive_cfg.position_a;
            speed_now  = drive_cfg.speed_a;
            ctl_now    = CwGo;
            seq_phase  = PH_REACH_A;
          end
          busy = 1'b0;
        end
        PH_REACH_A: begin
          if (!sw[StsReachedBit]) begin
            // saturates at all ones
            if (ticks_on_a != ElapsedMax) ticks_on_a = ticks_on_a + 1'b1;
            busy = 1'b0;
          end else begin
            wait_left = drive_cfg.pause_a;
            seq_phase = PH_PAUSE_A;
          end
        end
        PH_PAUSE_A: begin
          if (wait_left != 0) begin
            wait_left = wait_left - 1'b1;
          end else begin
            ticks_on_a = '0;
            ctl_now    = CwEnable;
            seq_phase  = PH_WAIT_EN_B;
          end
          busy = 1'b0;
        end
        PH_WAIT_EN_B: begin
          if (s == StsEnabled) begin
            target_now = drive_cfg.position_b;
            speed_now  = drive_cfg.speed_b;
            ctl_now    = CwGo;
            seq_phase  = PH_REACH_B;
          end
          busy = 1'b0;
        end
        PH_REACH_B: begin
          if (!sw[StsReachedBit]) begin
            busy = 1'b0;
          end else begin
            round_trips++;
            wait_left = drive_cfg.pause_b;
            seq_phase = PH_PAUSE_B;
          end
        end
        PH_PAUSE_B: begin
          if (wait_left != 0) wait_left = wait_left - 1'b1;
          else seq_phase = PH_LOOP;
          busy = 1'b0;
        end
        default: begin
          seq_phase = PH_START;
          busy      = 1'b0;
        end
      endcase
    end
    if (ticks_on_a > peak_elapsed) peak_elapsed = ticks_on_a;
    cmd.control_word     = ctl_now;
    cmd.target_position  = target_now;
    cmd.profile_velocity = speed_now;
    cmd.elapsed_ticks    = ticks_on_a;
    cmd.mode_write       = is_first;
    return cmd;
  endfunction

  // Status word that moves the sequence along, with random don't-care bits;
  // noise_pct of them are fully random instead
  function automatic logic [StatusWidth-1:0] pick_status(input int unsigned noise_pct,
                                                         input int unsigned reach_pct);
    logic [StatusWidth-1:0] sw;
    sw = 16'($urandom);
    if ($urandom_range(0, 99) < noise_pct) return sw;
    case (seq_phase)
      PH_WAIT_READY: sw = (sw & ~StsMask) | StsReady;
      PH_WAIT_ON: sw = (sw & ~StsMask) | StsOn;
      PH_WAIT_EN_A, PH_WAIT_EN_B: sw = (sw & ~StsMask) | StsEnabled;
      PH_REACH_A, PH_REACH_B: sw[StsReachedBit] = ($urandom_range(0, 99) < reach_pct);
      default: ;
    endcase
    return sw;
  endfunction

  // One status transaction; valid stays high until the next call or idle_channels
  task automatic send_status(input logic [StatusWidth-1:0] sw);
    int unsigned gap;
    gap = pick_gap(tx_idle_on);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    status_word <= sw;
    do @(posedge clk); while (in_stall);
    expected_commands.push_back(next_drive_command(sw));
    ticks_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_POSITION_A: drive_cfg.position_a = data;
      CFG_POSITION_B: drive_cfg.position_b = data;
      CFG_SPEED_A:    drive_cfg.speed_a    = data;
      CFG_SPEED_B:    drive_cfg.speed_b    = data;
      CFG_PAUSE_A:    drive_cfg.pause_a    = data[PauseWidth-1:0];
      CFG_PAUSE_B:    drive_cfg.pause_b    = data[PauseWidth-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic idle_channels();
    @(negedge clk);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    idle_channels();
    while (expected_commands.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] pos_a, pos_b, spd_a, spd_b, pz_a, pz_b);
    write_reg(CFG_POSITION_A, pos_a);
    write_reg(CFG_POSITION_B, pos_b);
    write_reg(CFG_SPEED_A, spd_a);
    write_reg(CFG_SPEED_B, spd_b);
    write_reg(CFG_PAUSE_A, pz_a);
    write_reg(CFG_PAUSE_B, pz_b);
    idle_channels();
  endtask

  task automatic program_random_regs();
    program_regs($urandom, $urandom, $urandom, $urandom, rand_pause(), rand_pause());
  endtask

  task automatic run_ticks(input int unsigned n, input int unsigned noise_pct,
                           input int unsigned reach_pct);
    repeat (n) send_status(pick_status(noise_pct, reach_pct));
  endtask

  // First tick, start pause, enable steps with wrong states in between,
  // a short A move and a B move with no pause, status extremes
  task automatic test_directed_sequence();
    logic [StatusWidth-1:0] steps[$];
    steps = '{16'h0021, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0031, 16'h0021,
              16'hFF33, 16'h0027, 16'h0027, 16'hFBFF, 16'h0000, 16'h0400, 16'h0000,
              16'h0000, 16'h0027, 16'h0400, 16'h0000, 16'h0027, 16'hFFFF};
    program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h8000_0002, 32'h0000_0000);
    foreach (steps[i]) send_status(steps[i]);
  endtask

  // Indexes 6 and 7 hold no register; writes to them must not change the results
  task automatic test_ignored_indexes();
    drain_results();
    write_reg(CfgSpareLo, 32'hFFFF_FFFF);
    write_reg(CfgSpareHi, 32'h5A5A_A5A5);
    idle_channels();
    run_ticks(30, 0, 40);
  endtask

  // Both pauses zero; pause A written with only the dropped top bit set
  task automatic test_zero_pauses();
    drain_results();
    program_regs($urandom, $urandom, $urandom, $urandom, 32'h8000_0000, 32'h0000_0000);
    run_ticks(200, 15, 35);
  endtask

  task automatic test_extreme_settings();
    drain_results();
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                 {1'b1, 31'd1}, {1'b0, 31'd3});
    run_ticks(150, 20, 30);
  endtask

  // Rare target-reached, so the A move's tick count climbs
  task automatic test_slow_reach();
    drain_results();
    program_random_regs();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    run_ticks(200, 10, 2);
  endtask

  // Several random settings, each with its own mix of idling
  task automatic test_random_moves();
    for (int round = 0; round < 4; round++) begin
      drain_results();
      program_random_regs();
      tx_idle_on = round[0];
      rx_idle_on = round[1];
      run_ticks(220, 20, 25);
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Largest pauses: once a wait starts the sequence stays in it for the rest of the run,
  // so this runs last
  task automatic test_endless_pause();
    drain_results();
    program_regs($urandom, $urandom, $urandom, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 300 && wait_left < 1000; i++) send_status(pick_status(0, 50));
    run_ticks(40, 20, 50);
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    int unsigned g;
    if (rx_hold != 0) begin
      rx_hold = rx_hold - 1;
    end else begin
      g = pick_gap(rx_idle_on);
      if (g != 0) begin
        out_stall <= 1'b1;
        rx_hold = g - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_commands.size() == 0) begin
        $display("%0t: result with none outstanding, control 0x%04h", $time, control_word);
        mismatches++;
      end else begin
        want = expected_commands.pop_front();
        compare_field("control_word", 32'(want.control_word), 32'(control_word));
        compare_field("target_position", want.target_position, target_position);
        compare_field("profile_velocity", want.profile_velocity, profile_velocity);
        compare_field("elapsed_ticks", 32'(want.elapsed_ticks), 32'(elapsed_ticks));
        compare_field("mode_write", 32'(want.mode_write), 32'(mode_write));
        commands_checked++;
      end
    end
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, QuietLimit, expected_commands.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    status_word = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    reset_sequencer_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_sequence();
    test_ignored_indexes();
    test_zero_pauses();
    test_extreme_settings();
    test_slow_reach();
    test_random_moves();
    test_endless_pause();

    drain_results();
    repeat (8) @(posedge clk);
    $display("Covered %0d status transactions, %0d results checked, %0d register writes.",
             ticks_sent, commands_checked, reg_writes);
    $display("Completed %0d A/B round trips; longest A move took %0d ticks.",
             round_trips, peak_elapsed);
    if (mismatches == 0 && expected_commands.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
